/* hdl/assert_macros.svh */
// assertion macros used by priority_task_list
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

/* hdl/ptl_pkg.sv */
// package for the priority task list: opcodes, widths, cell types
// no dependencies
`timescale 1ns / 1ps
package ptl_pkg;
	localparam int DefSlots = 16;
	localparam int MaxOut = 16;
	localparam logic [2:0] KIND_CREATE = 3'd0;
	localparam logic [2:0] KIND_DESTROY = 3'd1;
	localparam logic [2:0] KIND_RUN = 3'd2;
	localparam logic [2:0] KIND_FIND = 3'd3;
	localparam logic [2:0] KIND_COUNT = 3'd4;
	// cell contents; the list is held in order, position 0 is the head
	typedef struct packed {
		logic vld;
		logic [5:0] slot;
		logic [31:0] handle;
		logic [7:0] prio;
	} entry_t;
	// per-cycle command to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic shl;
		logic [7:0] prio;
		logic [5:0] slot;
		logic [31:0] handle;
	} cell_cmd_t;
endpackage

/* hdl/priority_task_list.sv */
// channel | signals                          | transfer when
// input   | kind handle prio slot            | start && !busy
// output  | task_slot task_handle ok         | strobe (one cycle,
//         | active_count last                |  no back pressure)
// create, destroy, count, spare kinds and run of an empty list pass through a done
// state before the next transfer; run gives one result a cycle, at most sixteen,
// set by rotating the occupied cells once round.
// find scans the chain one cell a cycle, then strobes a single result.
// reset clears all cells to empty; the receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module priority_task_list #(
	parameter int SLOTS = ptl_pkg::DefSlots
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] kind,
	input logic [31:0] handle,
	input logic [7:0] prio,
	input logic [3:0] slot,
	output logic strobe,
	output logic [3:0] task_slot,
	output logic [31:0] task_handle,
	output logic ok,
	output logic [4:0] active_count,
	output logic last
);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_FIND = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	logic [1:0] st_q;
	logic [CW-1:0] cnt_q, step_q;
	logic [SLOTS-1:0] used_q;
	logic [31:0] hnd_q;
	logic [5:0] freeslot;
	logic full;
	ptl_pkg::cell_cmd_t cmd;
	ptl_pkg::entry_t ent [SLOTS];
	logic [SLOTS:0] ins_c, del_c;
	logic acc, do_ins, do_del, hd_hit, run_end;
	logic [3:0] slot_res_q;
	logic ok_q, last_q, stb_q;
	logic [31:0] hres_q;
	logic [5:0] fnd_q;
	logic fnd_ok_q;

	assign acc = start && !busy;
	assign busy = (st_q != ST_IDLE);
	always_comb begin
		freeslot = '0;
		full = 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				freeslot = 6'(i);
				full = 1'b0;
			end
		end
	end
	assign do_ins = acc && kind == ptl_pkg::KIND_CREATE && !full;
	assign do_del = acc && kind == ptl_pkg::KIND_DESTROY && 32'(slot) < SLOTS
		&& used_q[slot];
	assign ins_c[0] = 1'b0;
	assign del_c[0] = 1'b0;
	assign cmd.ins = do_ins;
	assign cmd.del = do_del;
	// rotation during run and find walks the chain past cell 0
	assign cmd.shl = (st_q == ST_RUN) || (st_q == ST_FIND && step_q != cnt_q);
	assign cmd.prio = prio;
	assign cmd.slot = do_ins ? freeslot : 6'(slot);
	assign cmd.handle = handle;
	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			ptl_pkg::entry_t lft, rgt, nbr;
			if (g == 0) assign lft = ent[0];
			else assign lft = ent[g-1];
			if (g == SLOTS - 1) assign nbr = '0;
			else assign nbr = ent[g+1];
			// rotation wraps head to the last occupied cell; deletion shifts in empty
			assign rgt = (cmd.shl && cnt_q == CW'(g + 1)) ? ent[0] : nbr;
			ptl_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .left(lft), .right(rgt),
				.left_ins(ins_c[g]), .left_del(del_c[g]),
				.here_ins(ins_c[g+1]), .here_del(del_c[g+1]), .ent(ent[g])
			);
		end
	endgenerate
	assign hd_hit = ent[0].vld && ent[0].handle == hnd_q;
	assign run_end = (step_q == cnt_q - 1'b1) || (32'(step_q) == ptl_pkg::MaxOut - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			step_q <= '0;
			used_q <= '0;
			stb_q <= 1'b0;
			fnd_ok_q <= 1'b0;
		end else begin
			stb_q <= 1'b0;
			if (do_ins) begin
				used_q[freeslot[$clog2(SLOTS)-1:0]] <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (do_del) begin
				used_q[slot] <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						step_q <= '0;
						fnd_ok_q <= 1'b0;
						if (kind == ptl_pkg::KIND_RUN && cnt_q != '0) st_q <= ST_RUN;
						else if (kind == ptl_pkg::KIND_FIND) st_q <= ST_FIND;
						else begin
							st_q <= ST_DONE;
							stb_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					// results past the sixteenth are not strobed while the rotation finishes
					stb_q <= (32'(step_q) < ptl_pkg::MaxOut);
					step_q <= step_q + 1'b1;
					// full rotation needed to restore order, even past 16
					if (step_q == cnt_q - 1'b1) st_q <= ST_DONE;
				end
				ST_FIND: begin
					step_q <= step_q + 1'b1;
					if (hd_hit && (!fnd_ok_q || ent[0].slot < fnd_q))
						fnd_ok_q <= 1'b1;
					if (step_q == cnt_q) begin
						st_q <= ST_DONE;
						stb_q <= 1'b1;
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			hnd_q <= handle;
			slot_res_q <= do_ins ? freeslot[3:0] : 4'd0;
			ok_q <= do_ins;
			hres_q <= '0;
			last_q <= 1'b1;
		end
		if (st_q == ST_RUN) begin
			slot_res_q <= ent[0].slot[3:0];
			hres_q <= ent[0].handle;
			ok_q <= 1'b1;
			last_q <= run_end;
		end
		if (st_q == ST_FIND) begin
			if (hd_hit && (!fnd_ok_q || ent[0].slot < fnd_q)) fnd_q <= ent[0].slot;
			if (step_q == cnt_q) begin
				ok_q <= fnd_ok_q;
				slot_res_q <= fnd_ok_q ? fnd_q[3:0] : 4'd0;
				hres_q <= '0;
				last_q <= 1'b1;
			end
		end
	end
	assign strobe = stb_q;
	assign task_slot = slot_res_q;
	assign task_handle = hres_q;
	assign ok = ok_q;
	assign active_count = 5'(cnt_q);
	assign last = last_q;

	`ASSERT_IMPLIES(a_cnt_bound, clk, arst_n, 1'b1, 32'(cnt_q) <= SLOTS)
	`ASSERT_IMPLIES(a_cnt_used, clk, arst_n, 1'b1, 32'($countones(used_q)) == 32'(cnt_q))
	`ASSERT_NEXT(a_done_idle, clk, arst_n, st_q == ST_DONE, st_q == ST_IDLE)
endmodule

/* hdl/ptl_cell.sv */
// one list position of the sorted chain
// depends on ptl_pkg
`timescale 1ns / 1ps
module ptl_cell (
	input logic clk,
	input logic arst_n,
	input ptl_pkg::cell_cmd_t cmd,
	input ptl_pkg::entry_t left,
	input ptl_pkg::entry_t right,
	input logic left_ins,
	input logic left_del,
	output logic here_ins,
	output logic here_del,
	output ptl_pkg::entry_t ent
);
	ptl_pkg::entry_t ent_q;
	logic gt, hit;
	assign ent = ent_q;
	assign gt = ent_q.vld && (cmd.prio < ent_q.prio);
	assign hit = ent_q.vld && (ent_q.slot == cmd.slot);
	// insert point: first entry with greater priority, or first empty one
	assign here_ins = left_ins || gt || !ent_q.vld;
	assign here_del = left_del || hit;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.vld <= 1'b0;
			ent_q.slot <= '0;
			ent_q.handle <= '0;
			ent_q.prio <= '0;
		end else if (cmd.ins && here_ins) begin
			if (left_ins) ent_q <= left;
			else ent_q <= '{1'b1, cmd.slot, cmd.handle, cmd.prio};
		end else if ((cmd.del && here_del) || cmd.shl) begin
			ent_q <= right;
		end
	end
endmodule

/* tb/tb_priority_task_list.sv */
// testbench for priority_task_list: directed and random create, destroy, run, find, count
// depends on ptl_pkg and priority_task_list; checks each result against a local list model
`timescale 1ns / 1ps
module tb_priority_task_list;

	localparam int NSLOT = 16;
	localparam int NOLINK = 16;

	typedef struct packed {
		logic [3:0] task_slot;
		logic [31:0] task_handle;
		logic ok;
		logic [4:0] active_count;
		logic last;
	} result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] kind;
	logic [31:0] handle;
	logic [7:0] prio;
	logic [3:0] slot;
	logic strobe;
	logic [3:0] task_slot;
	logic [31:0] task_handle;
	logic ok;
	logic [4:0] active_count;
	logic last;

	// local copy of the task table
	logic act_q [NSLOT];
	logic [31:0] hdl_q [NSLOT];
	logic [7:0] pri_q [NSLOT];
	int prv_q [NSLOT];
	int nxt_q [NSLOT];

	result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	logic [31:0] used_handles[$];

	priority_task_list u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb_priority_task_list NOT OK");
			$finish;
		end
	end

	function automatic int count_active();
		int n;
		n = 0;
		for (int i = 0; i < NSLOT; i++)
			if (act_q[i])
				n++;
		return n;
	endfunction

	function automatic int head_slot();
		for (int i = 0; i < NSLOT; i++)
			if (act_q[i] && prv_q[i] == NOLINK)
				return i;
		return NOLINK;
	endfunction

	function automatic void push_result(int s, logic [31:0] h, logic k, logic l);
		result_t r;
		r.task_slot = s[3:0];
		r.task_handle = h;
		r.ok = k;
		r.active_count = 5'(count_active());
		r.last = l;
		pending_results.push_back(r);
	endfunction

	function automatic void insert_sorted(int n);
		int cur;
		int p;
		cur = head_slot();
		if (cur == NOLINK) begin
			prv_q[n] = NOLINK;
			nxt_q[n] = NOLINK;
			return;
		end
		for (int steps = 0; steps < NSLOT && cur < NSLOT; steps++) begin
			if (pri_q[n] < pri_q[cur]) begin
				p = prv_q[cur];
				prv_q[n] = p;
				nxt_q[n] = cur;
				if (p < NSLOT)
					nxt_q[p] = n;
				prv_q[cur] = n;
				return;
			end
			if (nxt_q[cur] >= NSLOT) begin
				prv_q[n] = cur;
				nxt_q[n] = NOLINK;
				nxt_q[cur] = n;
				return;
			end
			cur = nxt_q[cur];
		end
	endfunction

	function automatic void predict_list(logic [2:0] k, logic [31:0] h, logic [7:0] p,
			logic [3:0] s);
		int cur;
		int nx;
		int cnt;
		logic fin;
		case (k)
			ptl_pkg::KIND_CREATE: begin
				for (int i = 0; i < NSLOT; i++)
					if (!act_q[i]) begin
						hdl_q[i] = h;
						pri_q[i] = p;
						insert_sorted(i);
						act_q[i] = 1'b1;
						push_result(i, '0, 1'b1, 1'b1);
						return;
					end
				push_result(0, '0, 1'b0, 1'b1);
			end
			ptl_pkg::KIND_DESTROY: begin
				if (act_q[s]) begin
					act_q[s] = 1'b0;
					if (prv_q[s] >= NSLOT) begin
						if (nxt_q[s] < NSLOT)
							prv_q[nxt_q[s]] = NOLINK;
					end else if (nxt_q[s] >= NSLOT) begin
						nxt_q[prv_q[s]] = NOLINK;
					end else begin
						nxt_q[prv_q[s]] = nxt_q[s];
						prv_q[nxt_q[s]] = prv_q[s];
					end
				end
				push_result(0, '0, 1'b0, 1'b1);
			end
			ptl_pkg::KIND_RUN: begin
				cur = head_slot();
				cnt = 0;
				if (cur == NOLINK) begin
					push_result(0, '0, 1'b0, 1'b1);
					return;
				end
				while (cur < NSLOT && cnt < ptl_pkg::MaxOut) begin
					nx = nxt_q[cur];
					fin = (nx >= NSLOT) || (cnt == ptl_pkg::MaxOut - 1);
					push_result(cur, hdl_q[cur], 1'b1, fin);
					cnt++;
					if (fin)
						break;
					cur = nx;
				end
			end
			ptl_pkg::KIND_FIND: begin
				for (int i = 0; i < NSLOT; i++)
					if (act_q[i] && hdl_q[i] == h) begin
						push_result(i, '0, 1'b1, 1'b1);
						return;
					end
				push_result(0, '0, 1'b0, 1'b1);
			end
			default: push_result(0, '0, 1'b0, 1'b1);
		endcase
	endfunction

	// results are sampled at the edge that ends the strobe cycle
	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result slot=%0d", task_slot);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (task_slot !== want.task_slot) begin
					$error("task_slot exp %0d got %0d", want.task_slot, task_slot);
					errors++;
				end
				if (task_handle !== want.task_handle) begin
					$error("task_handle exp %h got %h", want.task_handle, task_handle);
					errors++;
				end
				if (ok !== want.ok) begin
					$error("ok exp %0d got %0d", want.ok, ok);
					errors++;
				end
				if (active_count !== want.active_count) begin
					$error("active_count exp %0d got %0d", want.active_count, active_count);
					errors++;
				end
				if (last !== want.last) begin
					$error("last exp %0d got %0d", want.last, last);
					errors++;
				end
			end
		end
	end

	// start stays high after a transfer until the next idle cycle or drain
	task automatic send_item(logic [2:0] k, logic [31:0] h, logic [7:0] p, logic [3:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		handle <= h;
		prio <= p;
		slot <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// accepted at this edge
		predict_list(k, h, p, s);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(ptl_pkg::KIND_RUN, '0, '0, '0);
		send_item(ptl_pkg::KIND_COUNT, '0, '0, '0);
		send_item(ptl_pkg::KIND_FIND, 32'h0, '0, '0);
		send_item(ptl_pkg::KIND_CREATE, 32'hFFFF_FFFF, 8'hFF, '0);
		send_item(ptl_pkg::KIND_CREATE, 32'h0, 8'h00, 4'hF);
		send_item(ptl_pkg::KIND_CREATE, 32'h1234_5678, 8'h80, '0);
		// equal priority keeps arrival order
		send_item(ptl_pkg::KIND_CREATE, 32'hAAAA_5555, 8'h80, '0);
		send_item(ptl_pkg::KIND_RUN, '0, '0, '0);
		send_item(ptl_pkg::KIND_FIND, 32'hFFFF_FFFF, '0, '0);
		send_item(ptl_pkg::KIND_FIND, 32'hDEAD_BEEF, '0, '0);
		send_item(ptl_pkg::KIND_DESTROY, '0, '0, 4'd1);
		send_item(ptl_pkg::KIND_DESTROY, '0, '0, 4'd1);
		send_item(ptl_pkg::KIND_DESTROY, '0, '0, 4'hF);
		send_item(3'd5, 32'hFFFF_FFFF, 8'hFF, 4'hF);
		send_item(3'd6, '0, '0, '0);
		send_item(3'd7, '0, '0, '0);
		send_item(ptl_pkg::KIND_RUN, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_full_table();
		for (int i = 0; i < 15; i++)
			send_item(ptl_pkg::KIND_CREATE, $urandom, 8'($urandom_range(255)), '0);
		send_item(ptl_pkg::KIND_CREATE, 32'h5555_AAAA, 8'h01, '0);
		send_item(ptl_pkg::KIND_RUN, '0, '0, '0);
		send_item(ptl_pkg::KIND_COUNT, '0, '0, '0);
		for (int i = 15; i >= 0; i--)
			send_item(ptl_pkg::KIND_DESTROY, '0, '0, i[3:0]);
		send_item(ptl_pkg::KIND_RUN, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_random(int n);
		logic [31:0] h;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 35) begin
				h = $urandom;
				if (used_handles.size() > 0 && $urandom_range(3) == 0)
					h = used_handles[$urandom_range(used_handles.size() - 1)];
				used_handles.push_back(h);
				send_item(ptl_pkg::KIND_CREATE, h, 8'($urandom_range(1) ? $urandom_range(255)
					: $urandom_range(3)), 4'($urandom));
			end else if (r < 60) begin
				send_item(ptl_pkg::KIND_DESTROY, $urandom, 8'($urandom),
					4'($urandom_range(15)));
			end else if (r < 75) begin
				send_item(ptl_pkg::KIND_RUN, $urandom, 8'($urandom), 4'($urandom));
			end else if (r < 88) begin
				h = $urandom;
				if (used_handles.size() > 0 && $urandom_range(2) != 0)
					h = used_handles[$urandom_range(used_handles.size() - 1)];
				send_item(ptl_pkg::KIND_FIND, h, 8'($urandom), 4'($urandom));
			end else if (r < 96) begin
				send_item(ptl_pkg::KIND_COUNT, $urandom, 8'($urandom), 4'($urandom));
			end else begin
				send_item(3'($urandom_range(7, 5)), $urandom, 8'($urandom), 4'($urandom));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			act_q[i] = 1'b0;
			hdl_q[i] = '0;
			pri_q[i] = '0;
			prv_q[i] = 0;
			nxt_q[i] = 0;
		end
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= '0;
		handle <= '0;
		prio <= '0;
		slot <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_full_table();
		send_idle_pct = 15;
		test_random(130);
		wait_drained();
		send_idle_pct = 58;
		test_random(130);
		send_idle_pct = 0;
		test_random(110);
		wait_drained();
		if (errors == 0)
			$display("tb_priority_task_list OK");
		else
			$display("tb_priority_task_list NOT OK");
		$finish;
	end
endmodule
